### hw/rtl/oss_pkg.sv
// shared types, widths and register codes of the overlay show sequencer
package oss_pkg;

   localparam int TIME_W     = 64;
   localparam int REG_W      = 40;
   localparam int COUNT_W    = 8;
   localparam int OPA_FRAC   = 16;
   localparam int OPA_W      = OPA_FRAC + 1;
   localparam int IDX_W      = 3;
   localparam int DIV_CNT_W  = $clog2(OPA_FRAC);

   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [REG_W-1:0]   span_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [OPA_W-1:0]   opa_type;
   typedef logic [IDX_W-1:0]   idx_type;

   localparam opa_type OPA_ONE = opa_type'(1) << OPA_FRAC;

   // register indexes on the csr port
   localparam idx_type REG_IDLE_DELAY   = 3'd0;
   localparam idx_type REG_STABLE_TIME  = 3'd1;
   localparam idx_type REG_FADE_IN      = 3'd2;
   localparam idx_type REG_FULL_TIME    = 3'd3;
   localparam idx_type REG_FADE_OUT     = 3'd4;
   localparam idx_type REG_SHOW_CYCLE   = 3'd5;
   localparam idx_type REG_GRACE_TIME   = 3'd6;
   localparam idx_type REG_TARGET_COUNT = 3'd7;

   // register reset values
   localparam span_type  RST_IDLE_DELAY   = 40'd180000000000;
   localparam span_type  RST_STABLE_TIME  = 40'd5000000000;
   localparam span_type  RST_FADE_IN      = 40'd500000000;
   localparam span_type  RST_FULL_TIME    = 40'd3000000000;
   localparam span_type  RST_FADE_OUT     = 40'd500000000;
   localparam span_type  RST_SHOW_CYCLE   = 40'd5000000000;
   localparam span_type  RST_GRACE_TIME   = 40'd4000000000;
   localparam count_type RST_TARGET_COUNT = 8'd2;

   // event codes
   localparam logic OP_UPDATE   = 1'b0;
   localparam logic OP_ACTIVATE = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_STABLE = 2'd1,
      MODE_SHOW   = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      ST_READY,
      ST_GRACE,
      ST_DECIDE,
      ST_OPA0,
      ST_OPA1,
      ST_OPA2,
      ST_OPA3,
      ST_OPA4,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } state_type;

endpackage

### hw/rtl/overlay_show_sequencer_with_fade_unit.sv
// overlay show sequencer with fade: event sequencer, opacity phases and serial divider
// sequence: an activate transfer goes from the grace step straight to the result; an update transfer
// also runs the decide step and the opacity phases, where the rising and falling ramps run a
// bit-serial divider, one quotient bit per cycle; one item at a time, the next item taken the cycle
// after its result is registered, once the result register is free or draining
// reset: synchronous, active high; clears sequencer state, stored times and the output valid,
// and loads every csr with its default value
module overlay_show_sequencer_with_fade_unit
   import oss_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_op,
   input  logic [TIME_W-1:0]    req_now_time,
   input  logic [COUNT_W-1:0]   req_object_count,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_shown,
   output logic [OPA_W-1:0]     rsp_opacity,
   // configuration port
   input  logic                 csr_we,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   // configuration registers
   span_type  idle_delay_ff,  stable_time_ff, fade_in_ff, full_time_ff;
   span_type  fade_out_ff,    show_cycle_ff,  grace_time_ff;
   count_type target_count_ff;

   // sequencer state kept between items
   mode_type  mode_ff,         mode_in;
   time_type  mode_since_ff,   mode_since_in;
   time_type  show_start_ff,   show_start_in;
   time_type  grace_until_ff,  grace_until_in;
   time_type  stable_start_ff, stable_start_in;

   // control
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   logic      op_ff,        op_in;
   time_type  now_ff,       now_in;
   count_type count_ff,     count_in;
   logic      grace_hit_ff, grace_hit_in;
   logic [REG_W:0] sum_ff,  sum_in;
   time_type  e_ff,         e_in;
   logic      shown_ff,     shown_in;
   opa_type   opa_ff,       opa_in;

   // serial divider: remainder and quotient shift one bit per cycle
   span_type  rem_ff,       rem_in;
   span_type  div_ff,       div_in;
   logic [OPA_FRAC-1:0]  q_ff, q_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic      falling_ff,   falling_in;

   // output register payload
   logic      rsp_shown_ff,   rsp_shown_in;
   opa_type   rsp_opacity_ff, rsp_opacity_in;

   // decision helpers
   logic      accept;
   logic      rsp_load;
   logic      ms_zero;
   mode_type  m_eff;
   time_type  ms_eff;
   time_type  ss_eff;
   time_type  cmp_base;
   span_type  cmp_thr;
   logic [TIME_W:0] cmp_diff;
   logic      cmp_hit;
   logic      open_ok;
   logic      e_lt_fi, e_lt_sum, e_lt_cyc, x_ge_fo;
   time_type  x_full;
   logic [REG_W:0] r_sh;
   logic      r_ge;
   opa_type   q_round;

   assign req_stall   = (state_ff != ST_READY);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_shown   = rsp_shown_ff;
   assign rsp_opacity = rsp_opacity_ff;
   // result leaves for the output register once that register is free or draining
   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // a zero mode_since means the sequencer has never been stepped: start idle now
   assign ms_zero = (mode_since_ff == '0);
   assign m_eff   = ms_zero ? MODE_IDLE : mode_ff;
   assign ms_eff  = ms_zero ? now_ff : mode_since_ff;
   assign ss_eff  = (show_start_ff == '0) ? now_ff : show_start_ff;

   // shared elapsed-time check: now is past base and by at least the threshold
   always_comb begin
      case (m_eff)
         MODE_SHOW: begin
            cmp_base = ss_eff;
            cmp_thr  = show_cycle_ff;
         end
         MODE_STABLE: begin
            cmp_base = stable_start_ff;
            cmp_thr  = stable_time_ff;
         end
         default: begin
            cmp_base = ms_eff;
            cmp_thr  = idle_delay_ff;
         end
      endcase
   end

   assign cmp_diff = {1'b0, now_ff} - {1'b0, cmp_base};
   assign cmp_hit  = !cmp_diff[TIME_W] && (cmp_diff[TIME_W-1:0] != '0)
                     && (cmp_diff[TIME_W-1:0] >= time_type'(cmp_thr));

   // opacity phase checks, one used per state
   assign open_ok  = (mode_ff == MODE_SHOW) && (show_start_ff != '0)
                     && (now_ff > show_start_ff);
   assign e_lt_fi  = e_ff < time_type'(fade_in_ff);
   assign e_lt_sum = e_ff < time_type'(sum_ff);
   assign e_lt_cyc = e_ff < time_type'(show_cycle_ff);
   assign x_full   = e_ff - time_type'(sum_ff);
   assign x_ge_fo  = x_full >= time_type'(fade_out_ff);

   // divider step
   assign r_sh    = {rem_ff, 1'b0};
   assign r_ge    = r_sh >= {1'b0, div_ff};
   // falling ramp rounds the fraction up before taking it from one
   assign q_round = opa_type'(q_ff) + opa_type'(rem_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_READY:  if (accept) state_in = ST_GRACE;
         ST_GRACE:  state_in = (op_ff == OP_ACTIVATE) ? ST_DONE : ST_DECIDE;
         ST_DECIDE: state_in = ST_OPA0;
         ST_OPA0:   state_in = open_ok ? ST_OPA1 : ST_DONE;
         ST_OPA1:   state_in = e_lt_fi ? ST_DIV : ST_OPA2;
         ST_OPA2:   state_in = e_lt_sum ? ST_DONE : ST_OPA3;
         ST_OPA3:   state_in = e_lt_cyc ? ST_OPA4 : ST_DONE;
         ST_OPA4:   state_in = x_ge_fo ? ST_DONE : ST_DIV;
         ST_DIV:    if (cnt_ff == DIV_CNT_W'(OPA_FRAC - 1)) state_in = ST_FIN;
         ST_FIN:    state_in = ST_DONE;
         ST_DONE:   if (rsp_load) state_in = ST_READY;
         default:   state_in = ST_READY;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in         = mode_ff;
      mode_since_in   = mode_since_ff;
      show_start_in   = show_start_ff;
      grace_until_in  = grace_until_ff;
      stable_start_in = stable_start_ff;
      op_in           = op_ff;
      now_in          = now_ff;
      count_in        = count_ff;
      grace_hit_in    = grace_hit_ff;
      sum_in          = sum_ff;
      e_in            = e_ff;
      shown_in        = shown_ff;
      opa_in          = opa_ff;
      rem_in          = rem_ff;
      div_in          = div_ff;
      q_in            = q_ff;
      cnt_in          = cnt_ff;
      falling_in      = falling_ff;
      rsp_shown_in    = rsp_shown_ff;
      rsp_opacity_in  = rsp_opacity_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_READY: begin
            if (accept) begin
               op_in    = req_op;
               now_in   = req_now_time;
               count_in = req_object_count;
            end
         end
         ST_GRACE: begin
            opa_in = '0;
            if (op_ff == OP_ACTIVATE) begin
               // activate: open grace window and start showing, opacity is zero at start
               grace_until_in  = now_ff + time_type'(grace_time_ff);
               mode_in         = MODE_SHOW;
               mode_since_in   = now_ff;
               show_start_in   = now_ff;
               stable_start_in = '0;
               shown_in        = 1'b1;
            end else begin
               grace_hit_in = grace_until_ff > now_ff;
               sum_in       = {1'b0, fade_in_ff} + {1'b0, full_time_ff};
            end
         end
         ST_DECIDE: begin
            mode_in       = m_eff;
            mode_since_in = ms_eff;
            shown_in      = 1'b0;
            if (m_eff == MODE_SHOW) begin
               if (cmp_hit) begin
                  // showing period over
                  show_start_in = '0;
                  mode_in       = MODE_IDLE;
                  mode_since_in = now_ff;
               end else begin
                  show_start_in = ss_eff;
                  shown_in      = 1'b1;
               end
            end else if (grace_hit_ff) begin
               // inside the boot grace window showing is forced
               mode_in         = MODE_SHOW;
               mode_since_in   = now_ff;
               show_start_in   = now_ff;
               stable_start_in = '0;
               shown_in        = 1'b1;
            end else if (m_eff == MODE_IDLE) begin
               if (cmp_hit) begin
                  mode_in         = MODE_STABLE;
                  mode_since_in   = now_ff;
                  stable_start_in = '0;
               end
            end else if (m_eff == MODE_STABLE) begin
               if (count_ff == target_count_ff) begin
                  if (stable_start_ff == '0) begin
                     stable_start_in = now_ff;
                  end else if (cmp_hit) begin
                     mode_in         = MODE_SHOW;
                     mode_since_in   = now_ff;
                     show_start_in   = now_ff;
                     stable_start_in = '0;
                     shown_in        = 1'b1;
                  end
               end else begin
                  stable_start_in = '0;
               end
            end
         end
         ST_OPA0: begin
            e_in = now_ff - show_start_ff;
         end
         ST_OPA1: begin
            // rising ramp: e / fade_in
            if (e_lt_fi) begin
               rem_in     = e_ff[REG_W-1:0];
               div_in     = fade_in_ff;
               q_in       = '0;
               cnt_in     = '0;
               falling_in = 1'b0;
            end
         end
         ST_OPA2: begin
            if (e_lt_sum) opa_in = OPA_ONE;
         end
         ST_OPA3: begin
            // past the cycle end opacity stays zero
         end
         ST_OPA4: begin
            // falling ramp: (e - fade_in - full) / fade_out
            if (!x_ge_fo) begin
               rem_in     = x_full[REG_W-1:0];
               div_in     = fade_out_ff;
               q_in       = '0;
               cnt_in     = '0;
               falling_in = 1'b1;
            end
         end
         ST_DIV: begin
            rem_in = r_ge ? REG_W'(r_sh - {1'b0, div_ff}) : r_sh[REG_W-1:0];
            q_in   = {q_ff[OPA_FRAC-2:0], r_ge};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
         ST_FIN: begin
            opa_in = falling_ff ? (OPA_ONE - q_round) : opa_type'(q_ff);
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in   = 1'b1;
               rsp_shown_in   = shown_ff;
               rsp_opacity_in = opa_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_READY;
         rsp_valid_ff    <= 1'b0;
         mode_ff         <= MODE_IDLE;
         mode_since_ff   <= '0;
         show_start_ff   <= '0;
         grace_until_ff  <= '0;
         stable_start_ff <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         mode_ff         <= mode_in;
         mode_since_ff   <= mode_since_in;
         show_start_ff   <= show_start_in;
         grace_until_ff  <= grace_until_in;
         stable_start_ff <= stable_start_in;
      end
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_delay_ff   <= RST_IDLE_DELAY;
         stable_time_ff  <= RST_STABLE_TIME;
         fade_in_ff      <= RST_FADE_IN;
         full_time_ff    <= RST_FULL_TIME;
         fade_out_ff     <= RST_FADE_OUT;
         show_cycle_ff   <= RST_SHOW_CYCLE;
         grace_time_ff   <= RST_GRACE_TIME;
         target_count_ff <= RST_TARGET_COUNT;
      end else if (csr_we) begin
         case (csr_index)
            REG_IDLE_DELAY:   idle_delay_ff   <= csr_wdata;
            REG_STABLE_TIME:  stable_time_ff  <= csr_wdata;
            REG_FADE_IN:      fade_in_ff      <= csr_wdata;
            REG_FULL_TIME:    full_time_ff    <= csr_wdata;
            REG_FADE_OUT:     fade_out_ff     <= csr_wdata;
            REG_SHOW_CYCLE:   show_cycle_ff   <= csr_wdata;
            REG_GRACE_TIME:   grace_time_ff   <= csr_wdata;
            REG_TARGET_COUNT: target_count_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      now_ff         <= now_in;
      count_ff       <= count_in;
      grace_hit_ff   <= grace_hit_in;
      sum_ff         <= sum_in;
      e_ff           <= e_in;
      shown_ff       <= shown_in;
      opa_ff         <= opa_in;
      rem_ff         <= rem_in;
      div_ff         <= div_in;
      q_ff           <= q_in;
      cnt_ff         <= cnt_in;
      falling_ff     <= falling_in;
      rsp_shown_ff   <= rsp_shown_in;
      rsp_opacity_ff <= rsp_opacity_in;
   end

`ifndef SYNTHESIS
   // opacity never exceeds full scale
   a_opa_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_opacity <= OPA_ONE))
      else $error("opacity above full scale");

   // a hidden overlay carries no opacity
   a_hidden_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_shown) |-> (rsp_opacity == '0))
      else $error("opacity nonzero while not shown");

   // an accepted transfer starts the sequence at once
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_GRACE))
      else $error("accepted transfer did not start the sequence");

   // restoring divider keeps its remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");
`endif

endmodule
